// ----- rtl/core/krt_pkg.sv -----
// krt_pkg: shared types, codes and widths for the keyed record table.
// No dependencies.
`timescale 1ns / 1ps

package krt_pkg;

  localparam int KEY_W        = 31;
  localparam int AMT_W        = 32;
  localparam int SUM_W        = 37;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 104;
  localparam int CAPACITY_DEF = 32;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;
  localparam logic [FUNC_W-1:0] FN_LIST   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
  } rec_t;

  // chain command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,   // take record from the cell in front (insert at head)
    CMD_PULL,   // at or behind the hit, take record from the cell behind
    CMD_ROT     // rotate valid records toward the head
  } cmd_t;

endpackage

// ----- rtl/core/keyed_record_table.sv -----
// keyed_record_table: insert/remove/search/list over a compact chain of record cells.
// Insert, remove and search each give a single result, registered in state EXEC, which
// waits while the output stalls. A new transaction is taken only in IDLE; a list gives
// one record a cycle out of the head cell while the chain rotates unless the output stalls.
// Reset: clears record count, running total, state and output valid; record slots
// keep undefined contents until written. Depends on krt_pkg and krt_cell.
`timescale 1ns / 1ps

module keyed_record_table #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [krt_pkg::IN_DATA_W-1:0]     s_tdata,   // key[30:0], amount[62:31], zero
  input  logic [krt_pkg::FUNC_W-1:0]        s_tuser,   // func[1:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [krt_pkg::OUT_DATA_W-1:0]    m_tdata,   // key_out[30:0], amount_out[62:31],
                                                       // total_out[99:63], zero
  output logic [krt_pkg::STATUS_W-1:0]      m_tuser,   // status[2:0]
  output logic                              m_tlast
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {IDLE, EXEC, LIST, TOTAL} state_t;

  state_t                          state;
  logic [krt_pkg::FUNC_W-1:0]      op_func;
  logic [krt_pkg::KEY_W-1:0]       op_key;
  logic [krt_pkg::AMT_W-1:0]       op_amt;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                left;
  logic [krt_pkg::SUM_W-1:0]       sum;

  logic                            o_valid;
  logic [krt_pkg::STATUS_W-1:0]    o_status;
  logic [krt_pkg::KEY_W-1:0]       o_key;
  logic [krt_pkg::AMT_W-1:0]       o_amt;
  logic [krt_pkg::SUM_W-1:0]       o_tot;
  logic                            o_last;

  krt_pkg::rec_t                   cell_rec [CAPACITY];
  krt_pkg::rec_t                   new_rec;
  logic [CAPACITY:0]               vld;
  logic [CAPACITY:0]               hit;
  logic [krt_pkg::AMT_W-1:0]       sel_amt [CAPACITY+1];
  krt_pkg::cmd_t                   cmd;
  logic                            can_load;
  logic                            found;
  logic                            full;

  assign s_tready = (state == IDLE);
  assign m_tvalid = o_valid;
  assign m_tuser  = o_status;
  assign m_tlast  = o_last;
  assign m_tdata  = {4'b0, o_tot, o_amt, o_key};

  assign can_load = !o_valid || m_tready;
  assign found    = hit[CAPACITY];
  assign full     = (count == CNT_W'(CAPACITY));
  assign new_rec  = '{key: op_key, amount: op_amt};
  assign hit[0]     = 1'b0;
  assign sel_amt[0] = '0;
  assign vld[CAPACITY] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign vld[g] = (CNT_W'(g) < count);
      krt_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .vld      (vld[g]),
        .vld_next (vld[g+1]),
        .key_q    (op_key),
        .prev_rec ((g == 0) ? new_rec : cell_rec[(g == 0) ? 0 : g-1]),
        .next_rec ((g == CAPACITY-1) ? krt_pkg::rec_t'('0)
                                     : cell_rec[(g == CAPACITY-1) ? g : g+1]),
        .head_rec (cell_rec[0]),
        .hit_in   (hit[g]),
        .amt_in   (sel_amt[g]),
        .rec      (cell_rec[g]),
        .hit_out  (hit[g+1]),
        .amt_out  (sel_amt[g+1])
      );
    end
  endgenerate

  always_comb begin
    cmd = krt_pkg::CMD_HOLD;
    if (can_load) begin
      if (state == EXEC) begin
        if (op_func == krt_pkg::FN_INSERT && !found && !full) cmd = krt_pkg::CMD_PUSH;
        if (op_func == krt_pkg::FN_REMOVE && found)           cmd = krt_pkg::CMD_PULL;
      end else if (state == LIST) begin
        cmd = krt_pkg::CMD_ROT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      count   <= '0;
      sum     <= '0;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (can_load) o_valid <= 1'b0;
          if (s_tvalid) begin
            op_func <= s_tuser;
            op_key  <= s_tdata[krt_pkg::KEY_W-1:0];
            op_amt  <= s_tdata[krt_pkg::KEY_W +: krt_pkg::AMT_W];
            state   <= EXEC;
          end
        end
        EXEC: begin
          if (can_load) begin
            o_tot  <= '0;
            o_last <= 1'b1;
            unique case (op_func)
              krt_pkg::FN_INSERT: begin
                o_valid <= 1'b1;
                o_key   <= op_key;
                state   <= IDLE;
                if (found) begin
                  o_status <= krt_pkg::ST_DUP;
                  o_amt    <= '0;
                end else if (full) begin
                  o_status <= krt_pkg::ST_FULL;
                  o_amt    <= '0;
                end else begin
                  o_status <= krt_pkg::ST_OK;
                  o_amt    <= op_amt;
                  count    <= count + 1'b1;
                  sum      <= sum + krt_pkg::SUM_W'(op_amt);
                end
              end
              krt_pkg::FN_REMOVE: begin
                o_valid <= 1'b1;
                o_key   <= op_key;
                state   <= IDLE;
                if (!found) begin
                  o_status <= krt_pkg::ST_NOTFOUND;
                  o_amt    <= '0;
                end else begin
                  o_status <= krt_pkg::ST_OK;
                  o_amt    <= sel_amt[CAPACITY];
                  count    <= count - 1'b1;
                  sum      <= sum - krt_pkg::SUM_W'(sel_amt[CAPACITY]);
                end
              end
              krt_pkg::FN_SEARCH: begin
                o_valid <= 1'b1;
                o_key   <= op_key;
                state   <= IDLE;
                if (!found) begin
                  o_status <= krt_pkg::ST_NOTFOUND;
                  o_amt    <= '0;
                end else begin
                  o_status <= krt_pkg::ST_OK;
                  o_amt    <= sel_amt[CAPACITY];
                end
              end
              default: begin
                if (count == '0) begin
                  o_valid  <= 1'b1;
                  o_status <= krt_pkg::ST_EMPTY;
                  o_key    <= '0;
                  o_amt    <= '0;
                  state    <= IDLE;
                end else begin
                  o_valid <= 1'b0;
                  left    <= count;
                  state   <= LIST;
                end
              end
            endcase
          end
        end
        LIST: begin
          if (can_load) begin
            o_valid  <= 1'b1;
            o_status <= krt_pkg::ST_OK;
            o_key    <= cell_rec[0].key;
            o_amt    <= cell_rec[0].amount;
            o_tot    <= '0;
            o_last   <= 1'b0;
            left     <= left - 1'b1;
            if (left == CNT_W'(1)) state <= TOTAL;
          end
        end
        TOTAL: begin
          if (can_load) begin
            o_valid  <= 1'b1;
            o_status <= krt_pkg::ST_OK;
            o_key    <= '0;
            o_amt    <= '0;
            o_tot    <= sum;
            o_last   <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/krt_cell.sv -----
// krt_cell: one slot of the record chain; compares its key and shifts
// records with its neighbors. Depends on krt_pkg.
`timescale 1ns / 1ps

module krt_cell (
  input  logic                    clk,
  input  krt_pkg::cmd_t           cmd,
  input  logic                    vld,
  input  logic                    vld_next,
  input  logic [krt_pkg::KEY_W-1:0] key_q,
  input  krt_pkg::rec_t           prev_rec,
  input  krt_pkg::rec_t           next_rec,
  input  krt_pkg::rec_t           head_rec,
  input  logic                    hit_in,
  input  logic [krt_pkg::AMT_W-1:0] amt_in,
  output krt_pkg::rec_t           rec,
  output logic                    hit_out,
  output logic [krt_pkg::AMT_W-1:0] amt_out
);

  logic match;

  assign match   = vld && (rec.key == key_q);
  assign hit_out = hit_in | match;
  assign amt_out = amt_in | (match ? rec.amount : '0);

  always_ff @(posedge clk) begin
    unique case (cmd)
      krt_pkg::CMD_PUSH: rec <= prev_rec;
      krt_pkg::CMD_PULL: begin
        if (hit_out) rec <= next_rec;
      end
      krt_pkg::CMD_ROT: rec <= vld_next ? next_rec : head_rec;
      default: rec <= rec;
    endcase
  end

endmodule

// ----- rtl/core/krt_checker.sv -----
// krt_checker: port-level assertions for keyed_record_table, bound to the top level.
// Depends on krt_pkg and keyed_record_table.
`timescale 1ns / 1ps

module krt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [krt_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [krt_pkg::STATUS_W-1:0]   m_tuser,
  input logic                           m_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_total_only_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[99:63] == '0)
    else $error("total set on a record transaction");

  a_list_item_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == krt_pkg::ST_OK)
    else $error("non-final transaction with error status");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == krt_pkg::ST_EMPTY |-> m_tlast && m_tdata[99:0] == '0)
    else $error("empty-table transaction malformed");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- test/tb_keyed_record_table.sv -----
`timescale 1ns / 1ps
// tb_keyed_record_table: self-checking bench that runs insert/remove/search/list traffic
// against a shadow table under random idle gaps and backpressure on both streams.
// Depends on krt_pkg and the keyed_record_table RTL.

typedef struct packed {
  logic [krt_pkg::STATUS_W-1:0] status;
  logic [krt_pkg::KEY_W-1:0]    key;
  logic [krt_pkg::AMT_W-1:0]    amount;
  logic [krt_pkg::SUM_W-1:0]    total;
  logic                         last;
} table_response_t;

class record_table_tracker;
  logic [krt_pkg::KEY_W-1:0] shadow_keys[$];
  logic [krt_pkg::AMT_W-1:0] shadow_amounts[$];
  logic [krt_pkg::SUM_W-1:0] shadow_total = '0;
  table_response_t           awaited[$];
  int depth          = krt_pkg::CAPACITY_DEF;
  int mismatches     = 0;
  int responses_seen = 0;

  function int slot_of(logic [krt_pkg::KEY_W-1:0] key);
    foreach (shadow_keys[i]) begin
      if (shadow_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function void queue_response(logic [krt_pkg::STATUS_W-1:0] status,
                               logic [krt_pkg::KEY_W-1:0] key,
                               logic [krt_pkg::AMT_W-1:0] amount,
                               logic [krt_pkg::SUM_W-1:0] total, logic last);
    awaited.push_back({status, key, amount, total, last});
  endfunction

  function void note_request(logic [krt_pkg::FUNC_W-1:0] func,
                             logic [krt_pkg::KEY_W-1:0] key,
                             logic [krt_pkg::AMT_W-1:0] amount);
    int slot;
    slot = slot_of(key);
    case (func)
      krt_pkg::FN_INSERT: begin
        // duplicate wins over full
        if (slot >= 0) begin
          queue_response(krt_pkg::ST_DUP, key, '0, '0, 1'b1);
        end else if (shadow_keys.size() >= depth) begin
          queue_response(krt_pkg::ST_FULL, key, '0, '0, 1'b1);
        end else begin
          shadow_keys.push_front(key);
          shadow_amounts.push_front(amount);
          shadow_total += amount;
          queue_response(krt_pkg::ST_OK, key, amount, '0, 1'b1);
        end
      end
      krt_pkg::FN_REMOVE: begin
        if (slot < 0) begin
          queue_response(krt_pkg::ST_NOTFOUND, key, '0, '0, 1'b1);
        end else begin
          queue_response(krt_pkg::ST_OK, key, shadow_amounts[slot], '0, 1'b1);
          shadow_total -= shadow_amounts[slot];
          shadow_keys.delete(slot);
          shadow_amounts.delete(slot);
        end
      end
      krt_pkg::FN_SEARCH: begin
        if (slot < 0) begin
          queue_response(krt_pkg::ST_NOTFOUND, key, '0, '0, 1'b1);
        end else begin
          queue_response(krt_pkg::ST_OK, key, shadow_amounts[slot], '0, 1'b1);
        end
      end
      krt_pkg::FN_LIST: begin
        if (shadow_keys.size() == 0) begin
          queue_response(krt_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          foreach (shadow_keys[i]) begin
            queue_response(krt_pkg::ST_OK, shadow_keys[i], shadow_amounts[i], '0, 1'b0);
          end
          queue_response(krt_pkg::ST_OK, '0, '0, shadow_total, 1'b1);
        end
      end
    endcase
  endfunction

  function void compare(string field, logic [krt_pkg::SUM_W-1:0] want,
                        logic [krt_pkg::SUM_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s expected %h got %h", $time, field, want, got);
    end
  endfunction

  function void check_response(table_response_t got);
    table_response_t want;
    responses_seen++;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: response expected none got status %0d key %h", $time,
                 got.status, got.key);
      return;
    end
    want = awaited.pop_front();
    compare("status", want.status, got.status);
    compare("key_out", want.key, got.key);
    compare("amount_out", want.amount, got.amount);
    compare("total_out", want.total, got.total);
    compare("last", want.last, got.last);
  endfunction
endclass

module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int TABLE_DEPTH     = CAPACITY_DEF;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // key[30:0], amount[62:31], zero
  logic [FUNC_W-1:0]     s_tuser  = FN_INSERT;   // func[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // key_out[30:0], amount_out[62:31], total_out[99:63], zero
  logic [STATUS_W-1:0]   m_tuser;   // status[2:0]
  logic                  m_tlast;

  record_table_tracker tracker = new;
  int sent_count = 0;
  bit held_off   = 1'b0;

  keyed_record_table #(.CAPACITY(TABLE_DEPTH)) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] random_amount();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return AMT_W'($urandom);
    endcase
  endfunction

  // draw a stored key with the given odds, else a fresh one
  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    int n;
    n = tracker.shadow_keys.size();
    if (n > 0 && $urandom_range(0, 99) < hit_pct)
      return tracker.shadow_keys[$urandom_range(0, n - 1)];
    return random_key();
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                           logic [AMT_W-1:0] amount);
    int gap;
    gap = 0;
    if (sent_count % 50 >= 12 && $urandom_range(0, 99) < 45) gap = idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {1'b0, amount, key};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(func, key, amount);
    sent_count++;
  endtask

  task automatic send_mixed(int w_insert, int w_remove, int w_search, int hit_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_insert)
      send_item(FN_INSERT, pick_key(10), random_amount());
    else if (r < w_insert + w_remove)
      send_item(FN_REMOVE, pick_key(hit_pct), random_amount());
    else if (r < w_insert + w_remove + w_search)
      send_item(FN_SEARCH, pick_key(hit_pct), random_amount());
    else
      send_item(FN_LIST, random_key(), random_amount());
  endtask

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(FN_LIST, 31'h1234_5678, 32'hDEAD_BEEF);
    send_item(FN_SEARCH, 31'd5, '0);
    send_item(FN_REMOVE, 31'd5, '0);
    send_item(FN_INSERT, '0, '0);
    send_item(FN_INSERT, '1, '1);
    send_item(FN_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
    send_item(FN_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
    send_item(FN_INSERT, '0, 32'd123);
    send_item(FN_SEARCH, '1, '0);
    send_item(FN_SEARCH, '0, '1);
    send_item(FN_LIST, '0, '0);
    send_item(FN_REMOVE, 31'h2AAA_AAAA, '0);
    send_item(FN_REMOVE, 31'h5555_5555, '0);
    send_item(FN_LIST, '1, '1);
    send_item(FN_REMOVE, '1, '0);
    send_item(FN_REMOVE, '0, '0);
    send_item(FN_LIST, '0, '0);
    send_item(FN_SEARCH, '0, '0);

    // grow to capacity, then poke at the full table
    while (tracker.shadow_keys.size() < TABLE_DEPTH) send_mixed(85, 0, 12, 80);
    send_item(FN_INSERT, pick_key(100), random_amount());
    repeat (3) send_item(FN_INSERT, random_key(), random_amount());
    send_item(FN_SEARCH, pick_key(100), '0);
    send_item(FN_LIST, random_key(), random_amount());
    send_item(FN_REMOVE, pick_key(100), '0);
    send_item(FN_INSERT, random_key(), random_amount());
    send_item(FN_LIST, '0, '0);

    for (i = 0; i < 70; i++) send_mixed(35, 30, 25, 70);

    // drain back to empty
    while (tracker.shadow_keys.size() > 0) send_mixed(0, 85, 10, 90);
    send_item(FN_LIST, random_key(), random_amount());

    s_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("keyed_record_table: match");
    else
      $display("keyed_record_table: mismatch");
    $finish;
  end

  initial begin : sink
    int gap;
    int cyc;
    cyc = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && tracker.responses_seen >= 60) begin
        // long hold-off so the table backs up into the input
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (cyc % 200 >= 60 && $urandom_range(0, 99) < 30) begin
        gap = idle_length();
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        cyc += gap;
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
        cyc++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_response({m_tuser, m_tdata[KEY_W-1:0],
                              m_tdata[KEY_W+AMT_W-1:KEY_W],
                              m_tdata[KEY_W+AMT_W+SUM_W-1:KEY_W+AMT_W], m_tlast});
  end

  initial begin : watchdog
    #20_000_000;
    $display("keyed_record_table: mismatch");
    $finish;
  end
endmodule
